// ----- src/skd_pkg.sv -----
// ----------------------------------------------------------------------------
// skd_pkg: shared types and constants for the spline knot slope block
// beat layouts, sequencer states, unit request/response groups, helpers
// ----------------------------------------------------------------------------
package skd_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 10;
  localparam int DIFF_W = 33;
  localparam int ACC_W  = 35;

  // floor(2^32 / 3), reciprocal for the divide by three
  localparam logic [30:0] DIV3_RECIP = 31'd1431655765;

  localparam logic [1:0] TERM_LAST = 2'd3;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] knot_pos;
    logic signed [DATA_W-1:0] fit_value;
    logic signed [DATA_W-1:0] curv_coef;
    logic signed [DATA_W-1:0] split_lo;
    logic signed [DATA_W-1:0] split_hi;
    logic                     last_knot;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] slope;
    logic [IDX_W-1:0]         knot_index;
    logic                     spacing_error;
    logic                     last_slope;
  } out_beat_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] num;
    logic signed [DIFF_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic                     fault;
    logic signed [DATA_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                     en;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } mul_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_SHORT,
    ST_DS0,
    ST_DR,
    ST_MP,
    ST_DIV6,
    ST_EMIT0,
    ST_EMIT1,
    ST_TD1,
    ST_TD2,
    ST_TM1,
    ST_TM2,
    ST_TACC,
    ST_EMITI,
    ST_FD,
    ST_FM,
    ST_EMITF,
    ST_DONE
  } state_e;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > ACC_W'(S32_MAX)) r = S32_MAX;
    else if (v < ACC_W'(S32_MIN)) r = S32_MIN;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] half(input logic signed [DATA_W-1:0] x);
    logic signed [DATA_W-1:0] s;
    s = x + $signed({31'd0, x[DATA_W-1]});
    return s >>> 1;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_pos(input logic signed [DATA_W-1:0] x);
    return x[DATA_W-1] ? '0 : x;
  endfunction

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

endpackage

// ----- src/skd_chan_if.sv -----
// ----------------------------------------------------------------------------
// skd_chan_if: valid/ready channel
// carries one beat of payload type T per handshake
// ----------------------------------------------------------------------------
interface skd_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/skd_div.sv -----
// ----------------------------------------------------------------------------
// skd_div: iterative fixed-point divider
// (num << FRAC_BITS) / den, truncated, saturated to 32 bits, one bit a cycle
// ----------------------------------------------------------------------------
module skd_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skd_pkg::div_req_t req_i,
  output skd_pkg::div_rsp_t rsp_o,
  output logic              busy_o
);

  localparam int DW = skd_pkg::DIFF_W;
  localparam int NW = DW + FRAC_BITS;
  localparam int HW = NW - 32;

  logic [DW-1:0] num_mag, den_mag;
  logic [NW-1:0] num_sh;
  logic [DW-1:0] hi_ext;
  logic          over, den_zero;

  logic          busy_q, done_q;
  logic [4:0]    itr_q;
  logic [DW-1:0] rem_q, dmag_q;
  logic [31:0]   lo_q, quo_q;
  logic          neg_q, sat_q, zero_q;

  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_d;

  assign num_mag  = req_i.num[DW-1] ? DW'(-req_i.num) : DW'(req_i.num);
  assign den_mag  = req_i.den[DW-1] ? DW'(-req_i.den) : DW'(req_i.den);
  assign num_sh   = {num_mag, {FRAC_BITS{1'b0}}};
  assign hi_ext   = DW'(num_sh[NW-1:NW-HW]);
  assign over     = hi_ext >= den_mag;
  assign den_zero = (req_i.den == '0);

  assign trial = {rem_q, lo_q[31]};
  assign ge    = trial >= {1'b0, dmag_q};
  assign rem_d = ge ? DW'(trial - {1'b0, dmag_q}) : trial[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      itr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (den_zero || over) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          itr_q  <= '0;
        end
      end else if (busy_q) begin
        itr_q <= itr_q + 5'd1;
        if (itr_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      zero_q <= den_zero;
      sat_q  <= over;
      neg_q  <= req_i.num[DW-1] ^ req_i.den[DW-1];
      rem_q  <= hi_ext;
      lo_q   <= num_sh[31:0];
      dmag_q <= den_mag;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      lo_q  <= {lo_q[30:0], 1'b0};
      quo_q <= {quo_q[30:0], ge};
    end
  end

  always_comb begin
    rsp_o.done  = done_q;
    rsp_o.fault = zero_q;
    if (zero_q) begin
      rsp_o.quot = '0;
    end else if (sat_q) begin
      rsp_o.quot = neg_q ? skd_pkg::S32_MIN : skd_pkg::S32_MAX;
    end else if (neg_q) begin
      rsp_o.quot = (quo_q > 32'h8000_0000) ? skd_pkg::S32_MIN : $signed(-quo_q);
    end else begin
      rsp_o.quot = quo_q[31] ? skd_pkg::S32_MAX : $signed(quo_q);
    end
  end

  assign busy_o = busy_q;

endmodule

// ----- src/skd_mul.sv -----
// ----------------------------------------------------------------------------
// skd_mul: registered fixed-point multiplier
// (a * b) / 2^FRAC_BITS truncated toward zero, saturated to 32 bits
// ----------------------------------------------------------------------------
module skd_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  skd_pkg::mul_req_t        req_i,
  output logic signed [31:0]       res_o
);

  localparam logic [63:0] BIAS = (64'd1 << FRAC_BITS) - 64'd1;

  logic signed [63:0] prod_q;
  logic signed [63:0] sum_s, sh_s;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= 64'(req_i.a) * 64'(req_i.b);
    end
  end

  assign sum_s = prod_q + $signed(prod_q[63] ? BIAS : 64'd0);
  assign sh_s  = sum_s >>> FRAC_BITS;

  always_comb begin
    if (sh_s > 64'(skd_pkg::S32_MAX)) res_o = skd_pkg::S32_MAX;
    else if (sh_s < 64'(skd_pkg::S32_MIN)) res_o = skd_pkg::S32_MIN;
    else res_o = sh_s[31:0];
  end

endmodule

// ----- src/spline_knot_derivative_recurrence_top.sv -----
// ----------------------------------------------------------------------------
// spline_knot_derivative_recurrence_top: knot slope recurrence
// sequencer around one shared divider and one shared multiplier
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  in_i     | in  | knot_pos, fit_value, curv_coef, split_lo, split_hi, last_knot
//  out_o    | out | slope, knot_index, spacing_error, last_slope
//
//  a divide step in skd_div runs its bit loop, but ends early on a zero
//  divisor or an overflowing quotient; eight divide steps per inner knot
//  in_i is ready only while idle; an emit waits while out_o holds an untaken beat
//  no clearing pass after reset
// ----------------------------------------------------------------------------
module spline_knot_derivative_recurrence_top #(
  parameter int MAX_KNOTS = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  skd_chan_if.sink    in_i,
  skd_chan_if.source  out_o
);

  localparam int CW = $clog2(MAX_KNOTS + 1);
  localparam int XW = CW + skd_pkg::IDX_W;
  localparam int AW = skd_pkg::ACC_W;

  skd_pkg::state_e state_q, state_d;

  skd_pkg::in_beat_t  in_q;
  skd_pkg::out_beat_t out_q, out_beat;
  logic               out_valid_q;

  logic signed [31:0] h0_q, h1_q, h2_q;
  logic signed [31:0] c0_q, c1_q, c2_q;
  logic signed [31:0] lo0_q, hi0_q, lo1_q, hi1_q;
  logic signed [31:0] z0_q, z1_q, prev_q;
  logic [CW-1:0]      cnt_q;

  logic signed [31:0]   r1_q, r2_q, m_q, s0_q;
  logic signed [AW-1:0] acc_q;
  logic                 err_q, fl_q, issued_q, sub_q;
  logic [1:0]           term_q;
  logic [62:0]          prod6_q;

  skd_pkg::div_req_t  div_req;
  skd_pkg::div_rsp_t  div_rsp;
  skd_pkg::mul_req_t  mul_req;
  logic signed [31:0] mul_res;
  logic               div_busy;

  logic div_st, mul_st, adv, slot_free, out_load, accept;
  logic signed [32:0] d_j, ha, hb, hc;

  logic [31:0]        m_abs;
  logic [30:0]        nh, q0, q6;
  logic [32:0]        r6;
  logic signed [31:0] div6, s_calc;
  logic [CW-1:0]      idx_cw;
  logic [XW-1:0]      idx_x;

  skd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp),
    .busy_o (div_busy)
  );

  skd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .res_o (mul_res)
  );

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == skd_pkg::ST_IDLE);
  assign slot_free = !out_valid_q || out_o.ready;

  // term operands
  assign ha = skd_pkg::sdiff(h0_q, h1_q);
  assign hb = skd_pkg::sdiff(h0_q, h2_q);
  assign hc = skd_pkg::sdiff(in_q.knot_pos, h1_q);

  always_comb begin
    case (term_q)
      2'd0:    d_j = skd_pkg::sdiff(h0_q, hi1_q);
      2'd1:    d_j = skd_pkg::sdiff(h0_q, lo1_q);
      2'd2:    d_j = skd_pkg::sdiff(hi1_q, h1_q);
      default: d_j = skd_pkg::sdiff(lo1_q, h1_q);
    endcase
  end

  // divide by six as halve then divide by three
  assign m_abs = m_q[31] ? 32'(-m_q) : 32'(m_q);
  assign nh    = m_abs[31:1];
  assign q0    = prod6_q[62:32];
  assign r6    = {2'b00, nh} - ({2'b00, q0} + {1'b0, q0, 1'b0});
  assign q6    = (r6 >= 33'd3) ? q0 + 31'd1 : q0;
  assign div6  = m_q[31] ? -$signed({1'b0, q6}) : $signed({1'b0, q6});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      skd_pkg::ST_IDLE:  if (accept) state_d = skd_pkg::ST_START;
      skd_pkg::ST_START: begin
        if (cnt_q < CW'(2)) begin
          state_d = in_q.last_knot ? skd_pkg::ST_SHORT : skd_pkg::ST_DONE;
        end else if (cnt_q == CW'(2)) begin
          state_d = skd_pkg::ST_DS0;
        end else begin
          state_d = skd_pkg::ST_TD1;
        end
      end
      skd_pkg::ST_SHORT: if (slot_free && (sub_q == cnt_q[0])) state_d = skd_pkg::ST_DONE;
      skd_pkg::ST_DS0:   if (adv) state_d = skd_pkg::ST_DR;
      skd_pkg::ST_DR:    if (adv) state_d = skd_pkg::ST_MP;
      skd_pkg::ST_MP:    if (adv) state_d = skd_pkg::ST_DIV6;
      skd_pkg::ST_DIV6:  state_d = skd_pkg::ST_EMIT0;
      skd_pkg::ST_EMIT0: if (slot_free) state_d = skd_pkg::ST_EMIT1;
      skd_pkg::ST_EMIT1, skd_pkg::ST_EMITI: begin
        if (slot_free) state_d = in_q.last_knot ? skd_pkg::ST_FD : skd_pkg::ST_DONE;
      end
      skd_pkg::ST_TD1:   if (adv) state_d = skd_pkg::ST_TD2;
      skd_pkg::ST_TD2:   if (adv) state_d = skd_pkg::ST_TM1;
      skd_pkg::ST_TM1:   if (adv) state_d = skd_pkg::ST_TM2;
      skd_pkg::ST_TM2:   if (adv) state_d = skd_pkg::ST_TACC;
      skd_pkg::ST_TACC: begin
        state_d = (term_q == skd_pkg::TERM_LAST) ? skd_pkg::ST_EMITI : skd_pkg::ST_TD1;
      end
      skd_pkg::ST_FD:    if (adv) state_d = skd_pkg::ST_FM;
      skd_pkg::ST_FM:    if (adv) state_d = skd_pkg::ST_EMITF;
      skd_pkg::ST_EMITF: if (slot_free) state_d = skd_pkg::ST_DONE;
      skd_pkg::ST_DONE:  state_d = skd_pkg::ST_IDLE;
      default:           state_d = skd_pkg::ST_IDLE;
    endcase
  end

  // unit requests and result beat
  always_comb begin
    div_st = 1'b0;
    mul_st = 1'b0;
    div_req.num = '0;
    div_req.den = '0;
    mul_req.a = '0;
    mul_req.b = '0;
    out_beat = '0;
    out_load = 1'b0;
    s_calc = '0;
    idx_cw = '0;
    case (state_q)
      skd_pkg::ST_DS0: begin
        div_st = 1'b1;
        div_req.num = skd_pkg::sdiff(z1_q, z0_q);
        div_req.den = ha;
      end
      skd_pkg::ST_DR: begin
        div_st = 1'b1;
        div_req.num = ha;
        div_req.den = hc;
      end
      skd_pkg::ST_TD1: begin
        div_st = 1'b1;
        div_req.num = d_j;
        div_req.den = ha;
      end
      skd_pkg::ST_TD2: begin
        div_st = 1'b1;
        div_req.num = d_j;
        div_req.den = term_q[1] ? hc : hb;
      end
      skd_pkg::ST_FD: begin
        div_st = 1'b1;
        div_req.num = skd_pkg::sdiff(in_q.knot_pos, h0_q);
        div_req.den = hc;
      end
      skd_pkg::ST_MP, skd_pkg::ST_FM: begin
        mul_st = 1'b1;
        mul_req.a = skd_pkg::clamp_pos(c1_q);
        mul_req.b = r2_q;
      end
      skd_pkg::ST_TM1: begin
        mul_st = 1'b1;
        mul_req.a = term_q[1] ? c1_q : c2_q;
        mul_req.b = r1_q;
      end
      skd_pkg::ST_TM2: begin
        mul_st = 1'b1;
        mul_req.a = m_q;
        mul_req.b = r2_q;
      end
      skd_pkg::ST_SHORT: begin
        out_load = slot_free;
        out_beat.knot_index = skd_pkg::IDX_W'(sub_q);
        out_beat.last_slope = (sub_q == cnt_q[0]);
      end
      skd_pkg::ST_EMIT0: begin
        out_load = slot_free;
        s_calc = err_q ? '0 : skd_pkg::sat32(AW'(r1_q) - AW'(div6));
        out_beat.slope = s_calc;
        out_beat.spacing_error = err_q;
      end
      skd_pkg::ST_EMIT1: begin
        out_load = slot_free;
        s_calc = fl_q ? '0 : skd_pkg::sat32(AW'(s0_q) + AW'(skd_pkg::half(m_q)));
        out_beat.slope = s_calc;
        out_beat.knot_index = skd_pkg::IDX_W'(1);
        out_beat.spacing_error = fl_q;
      end
      skd_pkg::ST_EMITI: begin
        out_load = slot_free;
        s_calc = err_q ? '0 : skd_pkg::sat32(acc_q);
        idx_cw = cnt_q - CW'(1);
        out_beat.slope = s_calc;
        out_beat.spacing_error = err_q;
      end
      skd_pkg::ST_EMITF: begin
        out_load = slot_free;
        s_calc = fl_q ? '0 : skd_pkg::sat32(AW'(prev_q) + AW'(skd_pkg::half(m_q)));
        idx_cw = cnt_q;
        out_beat.slope = s_calc;
        out_beat.spacing_error = fl_q;
        out_beat.last_slope = 1'b1;
      end
      default: begin
      end
    endcase
    if (state_q == skd_pkg::ST_EMITI || state_q == skd_pkg::ST_EMITF) begin
      if (idx_cw >= CW'(MAX_KNOTS - 1)) idx_cw = CW'(MAX_KNOTS - 1);
      idx_x = XW'(idx_cw);
      out_beat.knot_index = idx_x[skd_pkg::IDX_W-1:0];
    end else begin
      idx_x = '0;
    end
    div_req.start = div_st && !issued_q;
    mul_req.en    = mul_st && !issued_q;
    adv = div_st ? (issued_q && div_rsp.done) : (mul_st ? issued_q : 1'b1);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skd_pkg::ST_IDLE;
      issued_q    <= 1'b0;
      term_q      <= '0;
      sub_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= (div_st || mul_st) && !adv;
      if (state_q == skd_pkg::ST_START) begin
        term_q <= '0;
        sub_q  <= 1'b0;
      end
      if (state_q == skd_pkg::ST_TACC) term_q <= term_q + 2'd1;
      if (state_q == skd_pkg::ST_SHORT && slot_free) sub_q <= 1'b1;
      if (state_q == skd_pkg::ST_DONE) begin
        if (in_q.last_knot) cnt_q <= '0;
        else if (cnt_q < CW'(MAX_KNOTS)) cnt_q <= cnt_q + CW'(1);
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_i.data;
    if (out_load) out_q <= out_beat;
    case (state_q)
      skd_pkg::ST_START: begin
        err_q <= 1'b0;
        acc_q <= AW'(prev_q);
      end
      skd_pkg::ST_DS0, skd_pkg::ST_TD1: begin
        if (issued_q && div_rsp.done) begin
          r1_q  <= div_rsp.quot;
          err_q <= err_q | div_rsp.fault;
        end
      end
      skd_pkg::ST_DR, skd_pkg::ST_TD2, skd_pkg::ST_FD: begin
        if (issued_q && div_rsp.done) begin
          r2_q  <= div_rsp.quot;
          fl_q  <= div_rsp.fault;
          err_q <= err_q | div_rsp.fault;
        end
      end
      skd_pkg::ST_MP, skd_pkg::ST_TM1, skd_pkg::ST_TM2, skd_pkg::ST_FM: begin
        if (issued_q) m_q <= mul_res;
      end
      skd_pkg::ST_DIV6: prod6_q <= {32'd0, nh} * {32'd0, skd_pkg::DIV3_RECIP};
      skd_pkg::ST_EMIT0: s0_q <= s_calc;
      skd_pkg::ST_EMIT1, skd_pkg::ST_EMITI: prev_q <= s_calc;
      skd_pkg::ST_TACC: begin
        if (term_q == 2'd0 || term_q == skd_pkg::TERM_LAST) begin
          acc_q <= acc_q - AW'(skd_pkg::half(m_q));
        end else begin
          acc_q <= acc_q + AW'(skd_pkg::half(m_q));
        end
      end
      skd_pkg::ST_DONE: begin
        if (!in_q.last_knot) begin
          if (cnt_q == CW'(0)) z0_q <= in_q.fit_value;
          if (cnt_q == CW'(1)) z1_q <= in_q.fit_value;
          h2_q  <= h1_q;
          h1_q  <= h0_q;
          h0_q  <= in_q.knot_pos;
          c2_q  <= c1_q;
          c1_q  <= c0_q;
          c0_q  <= in_q.curv_coef;
          lo1_q <= lo0_q;
          hi1_q <= hi0_q;
          lo0_q <= in_q.split_lo;
          hi0_q <= in_q.split_hi;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("input ready right after accept");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_KNOTS))
    else $error("knot count out of range");

  a_last_ends_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_beat.last_slope) |=> state_q == skd_pkg::ST_DONE)
    else $error("final slope not followed by end of set");

  a_mul_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skd_pkg::ST_TM2 && issued_q) |-> $past(mul_req.en))
    else $error("product taken without a multiply");

endmodule
